/* src/lru_cache_byte_budget_defines.svh */
// Assertion macros used by the checker file.
`ifndef LRU_CACHE_BYTE_BUDGET_DEFINES_SVH
`define LRU_CACHE_BYTE_BUDGET_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lcb_pkg.sv */
`default_nettype none
package lcb_pkg;

  localparam int unsigned Entries = 64;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] size;
  } slot_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE,
    CELL_CLR
  } cell_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVICT,
    ST_INSERT,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

/* src/lcb_cell.sv */
`default_nettype none
module lcb_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lcb_pkg::cell_cmd_e cmd_i,
  input  wire lcb_pkg::slot_t    slot_i,
  input  wire logic [31:0]       key_i,
  output lcb_pkg::slot_t         slot_o,
  output logic                   match_o
);
  import lcb_pkg::*;

  logic        valid_q;
  logic [31:0] key_q, size_q;

  // Valid bit: take neighbor, clear on eviction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CELL_TAKE: valid_q <= slot_i.valid;
        CELL_CLR:  valid_q <= 1'b0;
        default:   valid_q <= valid_q;
      endcase
    end
  end

  // Payload follows the valid bit on a take
  always_ff @(posedge clk_i) begin
    if (cmd_i == CELL_TAKE) begin
      key_q  <= slot_i.key;
      size_q <= slot_i.size;
    end
  end

  assign slot_o  = '{valid: valid_q, key: key_q, size: size_q};
  assign match_o = valid_q && (key_q == key_i);

endmodule
`default_nettype wire

/* src/lru_cache_byte_budget.sv */
`default_nettype none
// LRU cache under a byte budget.
// Request channel: drive item_key_i and item_size_i with start; the item is
// taken at a clock edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Result channel: done_o is high for exactly one cycle with hit_o, stored_o,
// evicted_count_o and free_bytes_o; the receiver cannot stall it.
// Entries sit in a row of cells ordered by recency, most recent at cell 0.
// A hit moves its entry to the front, a miss evicts from the tail end one
// entry per cycle as needed, then, if stored, shifts the whole row to insert at the front.
// A hit goes from ST_LOOK straight to ST_RESP; a miss goes through ST_EVICT,
// staying there while it evicts to free bytes, then to ST_INSERT if stored
// (the eviction for a full table is done on the way out of ST_EVICT). One
// item is in work at a time: a new item is taken only back in ST_IDLE.
// Budget register via APB, written at addresses 0 to 3 (paddr[2] low) and read
// at any address; reset value 1048576. Reset empties the cache and clears the used byte count.
module lru_cache_byte_budget (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] item_key_i,
  input  wire logic [31:0] item_size_i,
  output logic             done_o,
  output logic             hit_o,
  output logic             stored_o,
  output logic [6:0]       evicted_count_o,
  output logic [31:0]      free_bytes_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lcb_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] budget_q, used_q, used_d;
  logic [31:0] key_q, size_q;
  logic        hit_q, hit_d, stored_q, stored_d;
  logic [6:0]  evc_q, evc_d;

  slot_t       slots [Entries];
  slot_t       feed  [Entries];
  cell_cmd_e   cmds  [Entries];
  logic [Entries-1:0] match, sfx, valid_v, last;
  logic [31:0] hit_size, last_size, free_now;
  logic        any_hit, full, nonempty, fits;

  assign pready = 1'b1;
  assign prdata = budget_q;

  // Budget register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= 32'd1048576;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      budget_q <= pwdata;
    end
  end

  // Row of cells
  for (genvar i = 0; i < Entries; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign feed[i] = '{valid: 1'b1, key: key_q,
                         size: (state_q == ST_LOOK) ? hit_size : size_q};
    end else begin : g_body
      assign feed[i] = slots[i-1];
    end
    lcb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmds[i]),
      .slot_i  (feed[i]),
      .key_i   (key_q),
      .slot_o  (slots[i]),
      .match_o (match[i])
    );
    assign valid_v[i] = slots[i].valid;
  end

  // Match suffix, tail flag and selected sizes
  always_comb begin
    hit_size  = '0;
    last_size = '0;
    for (int i = 0; i < Entries; i++) begin
      sfx[i]  = |(match & ({Entries{1'b1}} << i));
      last[i] = valid_v[i] && ((i == Entries - 1) ? 1'b1 : !valid_v[(i + 1) % Entries]);
      hit_size  = hit_size  | (match[i] ? slots[i].size : 32'd0);
      last_size = last_size | (last[i]  ? slots[i].size : 32'd0);
    end
  end

  assign any_hit  = |match;
  assign full     = valid_v[Entries-1];
  assign nonempty = valid_v[0];
  assign free_now = (budget_q > used_q) ? (budget_q - used_q) : 32'd0;
  assign fits     = free_now >= size_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_LOOK;
      ST_LOOK:   state_d = any_hit ? ST_RESP : ST_EVICT;
      ST_EVICT: begin
        if (fits) state_d = ST_INSERT;
        else if (!nonempty) state_d = ST_RESP;
      end
      ST_INSERT: state_d = ST_RESP;
      ST_RESP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Cell commands and result bookkeeping
  always_comb begin
    used_d   = used_q;
    hit_d    = hit_q;
    stored_d = stored_q;
    evc_d    = evc_q;
    for (int i = 0; i < Entries; i++) cmds[i] = CELL_HOLD;
    case (state_q)
      ST_IDLE: begin
        hit_d    = 1'b0;
        stored_d = 1'b0;
        evc_d    = '0;
      end
      ST_LOOK: begin
        if (any_hit) begin
          hit_d    = 1'b1;
          stored_d = 1'b1;
          for (int i = 0; i < Entries; i++)
            if (i == 0 || sfx[i]) cmds[i] = CELL_TAKE;
        end
      end
      ST_EVICT: begin
        if ((!fits && nonempty) || (fits && full)) begin
          for (int i = 0; i < Entries; i++)
            if (last[i]) cmds[i] = CELL_CLR;
          used_d = (used_q >= last_size) ? (used_q - last_size) : 32'd0;
          if (evc_q != 7'd127) evc_d = evc_q + 7'd1;
        end
      end
      ST_INSERT: begin
        for (int i = 0; i < Entries; i++) cmds[i] = CELL_TAKE;
        used_d   = used_q + size_q;
        stored_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      hit_q    <= 1'b0;
      stored_q <= 1'b0;
      evc_q    <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      hit_q    <= hit_d;
      stored_q <= stored_d;
      evc_q    <= evc_d;
    end
  end

  // Latch the request item
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      key_q  <= item_key_i;
      size_q <= item_size_i;
    end
  end

  // Outputs
  always_comb begin
    busy            = (state_q != ST_IDLE);
    done_o          = (state_q == ST_RESP);
    hit_o           = hit_q;
    stored_o        = stored_q;
    evicted_count_o = evc_q;
    free_bytes_o    = free_now;
  end

endmodule
`default_nettype wire

/* src/lcb_checker.sv */
`default_nettype none
`include "lru_cache_byte_budget_defines.svh"
module lcb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic        hit_o,
  input wire logic        stored_o,
  input wire logic [6:0]  evicted_count_o
);
  `LCB_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted item did not raise busy")
  `LCB_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy, "result strobe longer than one cycle")
  `LCB_ASSERT_NOW(a_hit_clean, done_o && hit_o, stored_o && evicted_count_o == 7'd0, "bad hit result")
  `LCB_ASSERT_NOW(a_done_busy, done_o, busy, "result outside a request")
endmodule

bind lru_cache_byte_budget lcb_checker u_lcb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .stored_o        (stored_o),
  .evicted_count_o (evicted_count_o)
);
`default_nettype wire
